// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KNN_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KNN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/knn_pkg.sv -----
// Shared constants, types and a helper function of the top-k image selector.
`timescale 1ns / 1ps

package knn_pkg;

  // Sizes of the descriptor, the kept list and the image space.
  localparam int VECTOR_DIM = 128;
  localparam int K_MAX      = 16;
  localparam int MAX_IMAGES = 1024;

  // Fixed field widths.
  localparam int OP_W   = 2;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 16;
  localparam int IMG_W  = 10;
  localparam int K_W    = 5;
  localparam int RANK_W = 4;
  localparam int DIST_W = 40;
  localparam int SQ_W   = 2 * VAL_W;

  // Widths derived from the list depth.
  localparam int CNT_W  = $clog2(K_MAX + 1);
  localparam int SLOT_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  // Request operation codes.
  localparam logic [OP_W-1:0] OP_LOAD_QUERY = 2'd0;
  localparam logic [OP_W-1:0] OP_FEATURE    = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH     = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic q_write;
    logic feat_load;
    logic sq_en;
    logic acc_en;
    logic list_ins;
    logic acc_clear;
    logic list_clear;
    logic emit_first;
    logic emit_next;
  } knn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic list_empty;
    logic feat_last;
    logic emit_last;
  } knn_stat_t;

  // Map the written k onto the range 1 to K_MAX.
  function automatic logic [CNT_W-1:0] clamp_k(input logic [K_W-1:0] k);
    logic [CNT_W-1:0] res;
    if (k == '0) begin
      res = CNT_W'(1);
    end else if (int'(k) > K_MAX) begin
      res = CNT_W'(K_MAX);
    end else begin
      res = CNT_W'(k);
    end
    return res;
  endfunction

endpackage

// ----- rtl/knn_ctrl.sv -----
// Controller state machine that sequences loads, distance steps, inserts and reports.
`timescale 1ns / 1ps

module knn_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [knn_pkg::OP_W-1:0] op,
  input  logic                     out_stall,
  input  knn_pkg::knn_stat_t       stat,
  output knn_pkg::knn_cmd_t        cmd,
  output logic                     busy,
  output logic                     out_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQUARE,
    S_ACCUM,
    S_INSERT,
    S_EMIT
  } state_t;

  state_t state;
  logic   accept;

  // A request is taken only in the idle state while no work is pending.
  assign accept = in_valid && !busy && (state == S_IDLE);

  // Command decode.
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            knn_pkg::OP_LOAD_QUERY: cmd.q_write = 1'b1;
            knn_pkg::OP_FEATURE:    cmd.feat_load = 1'b1;
            knn_pkg::OP_FINISH: begin
              cmd.acc_clear  = 1'b1;
              cmd.emit_first = !stat.list_empty;
            end
            default: ;
          endcase
        end
      end
      S_SQUARE: cmd.sq_en = 1'b1;
      S_ACCUM:  cmd.acc_en = 1'b1;
      S_INSERT: cmd.list_ins = 1'b1;
      S_EMIT: begin
        if (!out_stall) begin
          cmd.list_clear = stat.emit_last;
          cmd.emit_next  = !stat.emit_last;
        end
      end
      default: ;
    endcase
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      busy      <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          busy <= 1'b0;
          if (accept && op == knn_pkg::OP_FEATURE) begin
            state <= S_SQUARE;
            busy  <= 1'b1;
          end else if (accept && op == knn_pkg::OP_FINISH && !stat.list_empty) begin
            state     <= S_EMIT;
            busy      <= 1'b1;
            out_valid <= 1'b1;
          end
        end
        S_SQUARE: state <= S_ACCUM;
        S_ACCUM: begin
          if (stat.feat_last) begin
            state <= S_INSERT;
          end else begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        S_INSERT: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        S_EMIT: begin
          if (!out_stall && stat.emit_last) begin
            state     <= S_IDLE;
            busy      <= 1'b0;
            out_valid <= 1'b0;
          end
        end
        default: begin
          state     <= S_IDLE;
          busy      <= 1'b0;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ----- rtl/knn_dp.sv -----
// Datapath: query memory, squared distance accumulator, sorted list and result registers.
`timescale 1ns / 1ps

module knn_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  knn_pkg::knn_cmd_t          cmd,
  output knn_pkg::knn_stat_t         stat,
  input  logic [knn_pkg::POS_W-1:0]  position,
  input  logic [knn_pkg::VAL_W-1:0]  value,
  input  logic [knn_pkg::IMG_W-1:0]  image_index,
  input  logic                       last_coordinate,
  input  logic                       cfg_write,
  input  logic [knn_pkg::K_W-1:0]    k_closest,
  output logic [knn_pkg::RANK_W-1:0] rank,
  output logic [knn_pkg::IMG_W-1:0]  best_image,
  output logic                       last_result
);

  logic [knn_pkg::VAL_W-1:0]  query_mem [knn_pkg::VECTOR_DIM];
  logic [knn_pkg::VAL_W-1:0]  q_rd;
  logic [knn_pkg::VAL_W-1:0]  val_r;
  logic [knn_pkg::IMG_W-1:0]  img_r;
  logic                       pos_ok_r;
  logic                       last_r;
  logic                       pos_ok;
  logic [knn_pkg::VAL_W-1:0]  diff;
  logic [knn_pkg::SQ_W-1:0]   sq;
  logic [knn_pkg::DIST_W:0]   sum;
  logic [knn_pkg::DIST_W-1:0] acc;
  logic [knn_pkg::DIST_W-1:0] kd [knn_pkg::K_MAX];
  logic [knn_pkg::IMG_W-1:0]  ki [knn_pkg::K_MAX];
  logic [knn_pkg::CNT_W-1:0]  count;
  logic [knn_pkg::CNT_W-1:0]  k_eff;
  logic [knn_pkg::CNT_W-1:0]  k_new;
  logic [knn_pkg::K_MAX-1:0]  le;
  logic [knn_pkg::SLOT_W-1:0] k_last;
  logic                       img_ok;
  logic                       do_ins;
  logic [knn_pkg::RANK_W-1:0] rank_next;

  assign pos_ok = int'(position) < knn_pkg::VECTOR_DIM;

  // Query memory: written by query loads, read once per database coordinate.
  always_ff @(posedge clk) begin
    if (cmd.q_write && pos_ok) begin
      query_mem[position] <= value;
    end
    if (cmd.feat_load) begin
      q_rd     <= query_mem[position];
      val_r    <= value;
      img_r    <= image_index;
      pos_ok_r <= pos_ok;
      last_r   <= last_coordinate;
    end
  end

  // Absolute difference and its square, registered.
  assign diff = (val_r >= q_rd) ? (val_r - q_rd) : (q_rd - val_r);

  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      sq <= pos_ok_r ? (knn_pkg::SQ_W'(diff) * knn_pkg::SQ_W'(diff)) : '0;
    end
  end

  // Saturating distance accumulator, cleared after each feature and on finish.
  assign sum = {1'b0, acc} + (knn_pkg::DIST_W + 1)'(sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (cmd.acc_clear || cmd.list_ins) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= sum[knn_pkg::DIST_W] ? '1 : sum[knn_pkg::DIST_W-1:0];
    end
  end

  // Compare the finished distance against every held entry in parallel.
  always_comb begin
    for (int i = 0; i < knn_pkg::K_MAX; i++) begin
      le[i] = (knn_pkg::CNT_W'(i) < count) && (kd[i] <= acc);
    end
  end

  assign k_last = knn_pkg::SLOT_W'(k_eff - knn_pkg::CNT_W'(1));
  assign img_ok = int'(img_r) < knn_pkg::MAX_IMAGES;
  assign do_ins = cmd.list_ins && img_ok && ((count < k_eff) || !le[k_last]);

  // Each slot keeps its entry, takes the new one, or takes its upper neighbor.
  for (genvar g = 0; g < knn_pkg::K_MAX; g++) begin : g_slot
    if (g == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (do_ins && !le[0]) begin
          kd[0] <= acc;
          ki[0] <= img_r;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (do_ins && !le[g]) begin
          if (le[g-1]) begin
            kd[g] <= acc;
            ki[g] <= img_r;
          end else begin
            kd[g] <= kd[g-1];
            ki[g] <= ki[g-1];
          end
        end
      end
    end
  end

  // Fill count and effective k; a lower k drops the worst entries at once.
  assign k_new = knn_pkg::clamp_k(k_closest);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      k_eff <= knn_pkg::CNT_W'(1);
    end else if (cfg_write) begin
      k_eff <= k_new;
      if (count > k_new) begin
        count <= k_new;
      end
    end else if (cmd.list_clear) begin
      count <= '0;
    end else if (do_ins && count < k_eff) begin
      count <= count + knn_pkg::CNT_W'(1);
    end
  end

  // Result registers, walked one rank per taken result.
  assign rank_next = rank + knn_pkg::RANK_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.emit_first) begin
      rank        <= '0;
      best_image  <= ki[0];
      last_result <= (count == knn_pkg::CNT_W'(1));
    end else if (cmd.emit_next) begin
      rank        <= rank_next;
      best_image  <= ki[knn_pkg::SLOT_W'(rank_next)];
      last_result <= (knn_pkg::CNT_W'(rank) + knn_pkg::CNT_W'(2) == count);
    end
  end

  assign stat.list_empty = (count == '0);
  assign stat.feat_last  = last_r;
  assign stat.emit_last  = last_result;

endmodule

// ----- rtl/knn_top_k_image_selector.sv -----
// Top level of the top-k nearest image selector: controller plus datapath.
// A query load writes the query memory; a database coordinate passes the memory read,
// square and accumulate steps, and the last coordinate of a feature adds the list insert.
// A finish request on a non-empty list reports each kept entry in rank order, holding stalled results.
// No new coordinate is taken until the previous one has been through all of its steps.
// Synchronous active-high reset empties the list, zeroes the accumulator, sets k to 1.
`timescale 1ns / 1ps

module knn_top_k_image_selector (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [knn_pkg::OP_W-1:0]   op,
  input  logic [knn_pkg::POS_W-1:0]  position,
  input  logic [knn_pkg::VAL_W-1:0]  value,
  input  logic [knn_pkg::IMG_W-1:0]  image_index,
  input  logic                       last_coordinate,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [knn_pkg::RANK_W-1:0] rank,
  output logic [knn_pkg::IMG_W-1:0]  best_image,
  output logic                       last_result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [knn_pkg::K_W-1:0]    k_closest
);

  knn_pkg::knn_cmd_t  cmd;
  knn_pkg::knn_stat_t stat;
  logic               busy;
  logic               cfg_write;

  // Requests and register writes are refused while reset is held.
  assign in_stall  = busy || rst;
  assign cfg_ready = !rst;
  assign cfg_write = cfg_valid && cfg_ready;

  knn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .op        (op),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  knn_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .position        (position),
    .value           (value),
    .image_index     (image_index),
    .last_coordinate (last_coordinate),
    .cfg_write       (cfg_write),
    .k_closest       (k_closest),
    .rank            (rank),
    .best_image      (best_image),
    .last_result     (last_result)
  );

endmodule

// ----- rtl/knn_chk.sv -----
// Port-level checker for the top-k image selector, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module knn_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [knn_pkg::RANK_W-1:0] rank,
  input logic [knn_pkg::IMG_W-1:0]  best_image,
  input logic                       last_result
);

  // A stalled result holds its payload.
  `KNN_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(rank) && $stable(best_image) && $stable(last_result), "stalled result changed")

  // No request is taken while a report is under way.
  `KNN_ASSERT_SAME(a_busy_emit, clk, rst, out_valid, in_stall, "request taken during report")

  // A report starts at rank zero.
  `KNN_ASSERT_SAME(a_first_rank, clk, rst, $rose(out_valid), rank == '0, "report not starting at rank zero")

  // Ranks step by one until the final result.
  `KNN_ASSERT_NEXT(a_rank_step, clk, rst, out_valid && !out_stall && !last_result, out_valid && rank == $past(rank) + 4'd1, "rank did not advance by one")

  // The report ends after its final result is taken.
  `KNN_ASSERT_NEXT(a_report_end, clk, rst, out_valid && !out_stall && last_result, !out_valid, "result after final entry")

endmodule

bind knn_top_k_image_selector knn_chk u_knn_chk (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .rank        (rank),
  .best_image  (best_image),
  .last_result (last_result)
);
